### hw/rtl/btpc_pkg.sv
// Shared types, constants and helper functions for the barometer compensation pipeline.
`default_nettype none
package btpc_pkg;

    localparam int unsigned DivStages = 32;
    localparam int unsigned FirstDiv  = 13;
    localparam int unsigned NumStages = FirstDiv + DivStages + 3;

    localparam logic [1:0] RegTempCal  = 2'd0;
    localparam logic [1:0] RegPressLow = 2'd1;
    localparam logic [1:0] RegPressHi  = 2'd2;
    localparam logic [1:0] RegPressLst = 2'd3;

    localparam logic [31:0] PressOffset = 32'd64000;
    localparam logic [31:0] RawFull     = 32'd1048576;
    localparam logic [31:0] PressScale  = 32'd3125;
    localparam logic [31:0] P1Bias      = 32'd32768;
    localparam logic [31:0] TempRound   = 32'd128;

    typedef struct packed {
        logic [31:0] r0;
        logic [31:0] r1;
        logic [31:0] r2;
        logic [31:0] r3;
        logic [15:0] tsat;
        logic [19:0] adcp;
        logic        inv;
        logic        dbl;
    } stage_t;

    function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
        logic signed [31:0] s;
        s = $signed(x);
        return 32'(s >>> n);
    endfunction

    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

endpackage
`default_nettype wire

### hw/rtl/baro_temp_pressure_compensate_unit.sv
// Pipelined 32-bit integer barometer temperature and pressure compensation.
// One transaction is accepted per cycle; a stall at the output freezes the whole pipeline.
// The pressure divide is a 32-stage restoring divider, one quotient bit per stage.
// Reset clears all valid bits and the calibration registers to zero.
`default_nettype none
module baro_temp_pressure_compensate_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // raw_temperature[19:0], raw_pressure[39:20]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // temperature_centi[15:0], pressure_pa[47:16],
                                        // pressure_invalid[48], zero fill above
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);

    localparam int unsigned NS = btpc_pkg::NumStages;

    logic [47:0] temp_cal_reg;
    logic [63:0] press_low_reg;
    logic [63:0] press_hi_reg;
    logic [15:0] press_last_reg;

    btpc_pkg::stage_t st_reg  [NS];
    btpc_pkg::stage_t st_next [NS];
    logic [NS-1:0]    vld_reg;
    logic             adv;

    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;

    assign t1 = {16'd0, temp_cal_reg[15:0]};
    assign t2 = btpc_pkg::sx16(temp_cal_reg[31:16]);
    assign t3 = btpc_pkg::sx16(temp_cal_reg[47:32]);
    assign p1 = {16'd0, press_low_reg[15:0]};
    assign p2 = btpc_pkg::sx16(press_low_reg[31:16]);
    assign p3 = btpc_pkg::sx16(press_low_reg[47:32]);
    assign p4 = btpc_pkg::sx16(press_low_reg[63:48]);
    assign p5 = btpc_pkg::sx16(press_hi_reg[15:0]);
    assign p6 = btpc_pkg::sx16(press_hi_reg[31:16]);
    assign p7 = btpc_pkg::sx16(press_hi_reg[47:32]);
    assign p8 = btpc_pkg::sx16(press_hi_reg[63:48]);
    assign p9 = btpc_pkg::sx16(press_last_reg);

    assign adv       = !vld_reg[NS-1] || m_tready;
    assign s_tready  = adv;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = vld_reg[NS-1];
    assign m_tdata   = {7'd0, st_reg[NS-1].inv, st_reg[NS-1].r3, st_reg[NS-1].tsat};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_cal_reg   <= '0;
            press_low_reg  <= '0;
            press_hi_reg   <= '0;
            press_last_reg <= '0;
        end
        else if (cfg_valid && cfg_index[7:2] == 6'd0)
        begin
            case (cfg_index[1:0])
                btpc_pkg::RegTempCal:  temp_cal_reg   <= cfg_data[47:0];
                btpc_pkg::RegPressLow: press_low_reg  <= cfg_data;
                btpc_pkg::RegPressHi:  press_hi_reg   <= cfg_data;
                btpc_pkg::RegPressLst: press_last_reg <= cfg_data[15:0];
                default:               temp_cal_reg   <= temp_cal_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NS-2:0], s_tvalid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < NS; i++)
            begin
                st_reg[i] <= st_next[i];
            end
        end
    end

    always_comb
    begin
        logic [31:0] adct;
        logic [31:0] f5;
        logic [31:0] tmp;
        logic [31:0] aa;
        logic [31:0] pq;
        logic [32:0] trem;
        logic [31:0] pv;

        adct = {12'd0, s_tdata[19:0]};
        for (int i = 0; i < NS; i++)
        begin
            st_next[i] = (i == 0) ? st_reg[0] : st_reg[i-1];
        end

        st_next[0].adcp = s_tdata[39:20];
        st_next[0].r0 = (adct >> 3) - (t1 << 1);
        st_next[0].r1 = (adct >> 4) - t1;

        st_next[1].r0 = st_reg[0].r0 * t2;
        st_next[1].r1 = st_reg[0].r1 * st_reg[0].r1;

        st_next[2].r0 = btpc_pkg::asr(st_reg[1].r0, 11);
        st_next[2].r1 = btpc_pkg::asr(st_reg[1].r1, 12);

        st_next[3].r1 = st_reg[2].r1 * t3;

        st_next[4].r0 = st_reg[3].r0 + btpc_pkg::asr(st_reg[3].r1, 14);

        f5  = st_reg[4].r0 * 32'd5;
        tmp = btpc_pkg::asr(f5 + btpc_pkg::TempRound, 8);
        if (tmp[31])
        begin
            st_next[5].tsat = (tmp < 32'hFFFF8000) ? 16'h8000 : tmp[15:0];
        end
        else
        begin
            st_next[5].tsat = (tmp > 32'h00007FFF) ? 16'h7FFF : tmp[15:0];
        end
        st_next[5].r0 = btpc_pkg::asr(st_reg[4].r0, 1) - btpc_pkg::PressOffset;

        aa = btpc_pkg::asr(st_reg[5].r0, 2);
        st_next[6].r1 = aa * aa;
        st_next[6].r2 = st_reg[5].r0 * p5;
        st_next[6].r3 = p2 * st_reg[5].r0;

        st_next[7].r1 = btpc_pkg::asr(st_reg[6].r1, 11) * p6;
        st_next[7].r0 = p3 * btpc_pkg::asr(st_reg[6].r1, 13);

        st_next[8].r1 = btpc_pkg::asr(st_reg[7].r1 + (st_reg[7].r2 << 1), 2) + (p4 << 16);
        st_next[8].r0 = btpc_pkg::asr(btpc_pkg::asr(st_reg[7].r0, 3)
                        + btpc_pkg::asr(st_reg[7].r3, 1), 18);

        st_next[9].r0 = (btpc_pkg::P1Bias + st_reg[8].r0) * p1;

        st_next[10].r2  = btpc_pkg::asr(st_reg[9].r0, 15);
        st_next[10].inv = (btpc_pkg::asr(st_reg[9].r0, 15) == 32'd0);
        st_next[10].r1  = (btpc_pkg::RawFull - {12'd0, st_reg[9].adcp})
                          - btpc_pkg::asr(st_reg[9].r1, 12);

        st_next[11].r1 = st_reg[10].r1 * btpc_pkg::PressScale;

        st_next[12].dbl = st_reg[11].r1[31];
        st_next[12].r1  = st_reg[11].r1[31] ? st_reg[11].r1 : (st_reg[11].r1 << 1);
        st_next[12].r0  = 32'd0;

        for (int k = 0; k < btpc_pkg::DivStages; k++)
        begin
            trem = {st_reg[btpc_pkg::FirstDiv+k-1].r0, st_reg[btpc_pkg::FirstDiv+k-1].r1[31]};
            if (trem >= {1'b0, st_reg[btpc_pkg::FirstDiv+k-1].r2})
            begin
                trem = trem - {1'b0, st_reg[btpc_pkg::FirstDiv+k-1].r2};
                st_next[btpc_pkg::FirstDiv+k].r1 = {st_reg[btpc_pkg::FirstDiv+k-1].r1[30:0], 1'b1};
            end
            else
            begin
                st_next[btpc_pkg::FirstDiv+k].r1 = {st_reg[btpc_pkg::FirstDiv+k-1].r1[30:0], 1'b0};
            end
            st_next[btpc_pkg::FirstDiv+k].r0 = trem[31:0];
        end

        pv = st_reg[NS-4].dbl ? (st_reg[NS-4].r1 << 1) : st_reg[NS-4].r1;
        pq = (pv >> 3) * (pv >> 3);
        st_next[NS-3].r3 = pv;
        st_next[NS-3].r0 = pq >> 13;
        st_next[NS-3].r1 = (pv >> 2) * p8;

        st_next[NS-2].r0 = p9 * st_reg[NS-3].r0;

        st_next[NS-1].r3 = st_reg[NS-2].inv ? 32'd0 :
            st_reg[NS-2].r3 + btpc_pkg::asr(btpc_pkg::asr(st_reg[NS-2].r0, 12)
            + btpc_pkg::asr(st_reg[NS-2].r1, 13) + p7, 4);
    end

endmodule
`default_nettype wire

### bench/tb.sv
// Self-checking bench for the barometer compensation unit with a scoreboard class.
`default_nettype none

class comp_scoreboard;
    logic [63:0] temp_cal;
    logic [63:0] press_lo;
    logic [63:0] press_hi;
    logic [63:0] press_p9;
    logic [55:0] pending_results[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned invalid_seen;
    int unsigned sat_seen;

    function new();
        temp_cal = '0;
        press_lo = '0;
        press_hi = '0;
        press_p9 = '0;
        mismatches = 0;
        checked = 0;
        invalid_seen = 0;
        sat_seen = 0;
    endfunction

    function void write_reg(logic [7:0] idx, logic [63:0] val);
        if (idx == 8'(btpc_pkg::RegTempCal))
            temp_cal = {16'd0, val[47:0]};
        else if (idx == 8'(btpc_pkg::RegPressLow))
            press_lo = val;
        else if (idx == 8'(btpc_pkg::RegPressHi))
            press_hi = val;
        else if (idx == 8'(btpc_pkg::RegPressLst))
            press_p9 = {48'd0, val[15:0]};
    endfunction

    function logic [31:0] shr_s(logic [31:0] x, int n);
        logic signed [31:0] s;
        s = $signed(x);
        return 32'(s >>> n);
    endfunction

    function logic [31:0] ext16(logic [63:0] v, int pos);
        logic [15:0] s;
        s = v[pos +: 16];
        return {{16{s[15]}}, s};
    endfunction

    function logic [55:0] compensate(logic [19:0] adc_t, logic [19:0] adc_p);
        logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [31:0] a, b, d, fine, temp, p, q;
        logic [15:0] tsat;
        logic inv;
        t1 = {16'd0, temp_cal[15:0]};
        t2 = ext16(temp_cal, 16);
        t3 = ext16(temp_cal, 32);
        p1 = {16'd0, press_lo[15:0]};
        p2 = ext16(press_lo, 16);
        p3 = ext16(press_lo, 32);
        p4 = ext16(press_lo, 48);
        p5 = ext16(press_hi, 0);
        p6 = ext16(press_hi, 16);
        p7 = ext16(press_hi, 32);
        p8 = ext16(press_hi, 48);
        p9 = ext16(press_p9, 0);
        inv = 1'b0;
        a = shr_s(((32'(adc_t) >> 3) - (t1 << 1)) * t2, 11);
        d = (32'(adc_t) >> 4) - t1;
        b = shr_s(shr_s(d * d, 12) * t3, 14);
        fine = a + b;
        temp = shr_s(fine * 32'd5 + 32'd128, 8);
        if ($signed(temp) < -32768)
            tsat = 16'h8000;
        else if ($signed(temp) > 32767)
            tsat = 16'h7FFF;
        else
            tsat = temp[15:0];
        a = shr_s(fine, 1) - 32'd64000;
        q = shr_s(a, 2) * shr_s(a, 2);
        b = shr_s(q, 11) * p6;
        b = b + ((a * p5) << 1);
        b = shr_s(b, 2) + (p4 << 16);
        a = shr_s(shr_s(p3 * shr_s(q, 13), 3) + shr_s(p2 * a, 1), 18);
        a = shr_s((32'd32768 + a) * p1, 15);
        if (a == 32'd0) begin
            p = 32'd0;
            inv = 1'b1;
        end else begin
            p = ((32'd1048576 - 32'(adc_p)) - shr_s(b, 12)) * 32'd3125;
            if (p < 32'h80000000)
                p = (p << 1) / a;
            else
                p = (p / a) * 32'd2;
            q = ((p >> 3) * (p >> 3)) >> 13;
            a = shr_s(p9 * q, 12);
            b = shr_s((p >> 2) * p8, 13);
            p = p + shr_s(a + b + p7, 4);
        end
        return {7'd0, inv, p, tsat};
    endfunction

    function void note_input(logic [39:0] data);
        pending_results.push_back(compensate(data[19:0], data[39:20]));
    endfunction

    function int check_result(logic [55:0] got, output string msg);
        logic [55:0] want;
        checked++;
        if (pending_results.size() == 0) begin
            msg = $sformatf("unexpected result transaction %h", got);
            return 1;
        end
        want = pending_results.pop_front();
        if (want[48]) invalid_seen++;
        if (want[15:0] == 16'h7FFF || want[15:0] == 16'h8000) sat_seen++;
        msg = "";
        if (got[15:0] !== want[15:0])
            msg = {msg, $sformatf(" temperature_centi got %h want %h", got[15:0], want[15:0])};
        if (got[47:16] !== want[47:16])
            msg = {msg, $sformatf(" pressure_pa got %h want %h", got[47:16], want[47:16])};
        if (got[48] !== want[48])
            msg = {msg, $sformatf(" pressure_invalid got %b want %b", got[48], want[48])};
        if (got[55:49] !== want[55:49])
            msg = {msg, " fill bits not zero"};
        return msg != "";
    endfunction
endclass

module tb;
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [39:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [7:0] cfg_index = '0;
    logic [63:0] cfg_data = '0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_off = 1'b0;
    int unsigned error_count = 0;
    int unsigned sent_count = 0;
    comp_scoreboard compensation_sb;

    baro_temp_pressure_compensate_unit dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(string msg);
        $display("MISMATCH at %0t:%s", $realtime, msg);
        error_count++;
    endtask

    // The valid stays high after the write; the next task that moves on drops it.
    task automatic write_register(logic [7:0] idx, logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        compensation_sb.write_reg(idx, val);
    endtask

    task automatic send_reading(logic [19:0] raw_t, logic [19:0] raw_p);
        cfg_valid <= 1'b0;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {raw_p, raw_t};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        compensation_sb.note_input({raw_p, raw_t});
        sent_count++;
    endtask

    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        cfg_valid <= 1'b0;
        while (compensation_sb.pending_results.size() != 0) @(posedge clk);
        repeat (btpc_pkg::NumStages + 8) @(posedge clk);
    endtask

    always @(posedge clk) begin
        string msg;
        if (rst_n && m_tvalid && m_tready)
            if (compensation_sb.check_result(m_tdata, msg))
                report_mismatch(msg);
        m_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic logic [19:0] pick_raw();
        case ($urandom_range(5))
            0: return 20'h00000;
            1: return 20'hFFFFF;
            2: return 20'($urandom_range(300000, 700000));
            default: return 20'($urandom);
        endcase
    endfunction

    // Realistic calibration near typical datasheet values, with random spread in t1, t2 and p1.
    task automatic load_typical_calibration();
        logic [15:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        t1 = 16'($urandom_range(26000, 29000));
        t2 = 16'($urandom_range(25500, 27500));
        t3 = 16'(50);
        p1 = 16'($urandom_range(35000, 38000));
        p2 = -16'sd10685;
        p3 = 16'(3024);
        p4 = 16'(2855);
        p5 = 16'(140);
        p6 = -16'sd7;
        p7 = 16'(15500);
        p8 = -16'sd14600;
        p9 = 16'(6000);
        write_register(8'(btpc_pkg::RegTempCal), {16'($urandom), t3, t2, t1});
        write_register(8'(btpc_pkg::RegPressLow), {p4, p3, p2, p1});
        write_register(8'(btpc_pkg::RegPressHi), {p8, p7, p6, p5});
        write_register(8'(btpc_pkg::RegPressLst), {$urandom, 16'($urandom), p9});
    endtask

    task automatic load_random_calibration();
        write_register(8'(btpc_pkg::RegTempCal), {$urandom, $urandom});
        write_register(8'(btpc_pkg::RegPressLow), {$urandom, $urandom});
        write_register(8'(btpc_pkg::RegPressHi), {$urandom, $urandom});
        write_register(8'(btpc_pkg::RegPressLst), {$urandom, $urandom});
    endtask

    task automatic run_random(int count, int idle_pct, int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) send_reading(pick_raw(), pick_raw());
        drain_pipeline();
    endtask

    initial begin
        compensation_sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // With all calibration at zero the divisor term is zero.
        send_reading(20'h00000, 20'h00000);
        send_reading(20'hFFFFF, 20'hFFFFF);
        drain_pipeline();

        load_typical_calibration();
        send_reading(20'h00000, 20'h00000);
        send_reading(20'hFFFFF, 20'hFFFFF);
        send_reading(20'd519888, 20'd415148);
        send_reading(20'h80000, 20'h7FFFF);
        send_reading(20'h55555, 20'hAAAAA);
        send_reading(20'hAAAAA, 20'h55555);
        drain_pipeline();

        // Extreme coefficients, with raw readings at the ends of their range.
        write_register(8'(btpc_pkg::RegTempCal), {16'h0000, 16'h7FFF, 16'h7FFF, 16'h0000});
        write_register(8'(btpc_pkg::RegPressLow), 64'hFFFF_FFFF_FFFF_FFFF);
        write_register(8'(btpc_pkg::RegPressHi), 64'h8000_8000_8000_8000);
        write_register(8'(btpc_pkg::RegPressLst), 64'h0000_0000_0000_8000);
        send_reading(20'hFFFFF, 20'h00000);
        send_reading(20'h00000, 20'hFFFFF);
        drain_pipeline();
        write_register(8'(btpc_pkg::RegTempCal), {16'h0000, 16'h8000, 16'h8000, 16'hFFFF});
        write_register(8'(btpc_pkg::RegPressLst), 64'h0000_0000_0000_7FFF);
        write_register(8'd200, 64'h1234_5678_9ABC_DEF0);
        send_reading(20'hFFFFF, 20'hFFFFF);
        send_reading(20'h00000, 20'h00000);
        send_reading(20'h12345, 20'hFEDCB);
        drain_pipeline();

        load_typical_calibration();
        run_random(150, 0, 0);
        load_random_calibration();
        run_random(120, 48, 0);
        load_typical_calibration();
        run_random(150, 0, 48);
        load_random_calibration();
        run_random(120, 10, 10);

        // Hold the receiver off for a long stretch so the pipeline backs up.
        load_typical_calibration();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        fork
            begin
                hold_off = 1'b1;
                repeat (200) @(posedge clk);
                hold_off = 1'b0;
            end
            repeat (100) send_reading(pick_raw(), pick_raw());
        join
        drain_pipeline();

        load_random_calibration();
        run_random(175, 48, 48);
        write_register(8'(btpc_pkg::RegTempCal), 64'h0);
        write_register(8'(btpc_pkg::RegPressLow), 64'h0);
        write_register(8'(btpc_pkg::RegPressHi), 64'h0);
        write_register(8'(btpc_pkg::RegPressLst), 64'h0);
        run_random(20, 10, 10);

        $display("Covered %0d readings over zero, typical, extreme and random calibrations,",
                 sent_count);
        $display("with %0d invalid-divisor results and %0d saturated temperatures.",
                 compensation_sb.invalid_seen, compensation_sb.sat_seen);
        if (error_count == 0 && compensation_sb.pending_results.size() == 0)
            $display("PASS baro_temp_pressure_compensate_unit");
        else
            $display("FAIL baro_temp_pressure_compensate_unit");
        $finish;
    end

    initial begin
        #2000000;
        $display("FAIL baro_temp_pressure_compensate_unit");
        $finish;
    end
endmodule

`default_nettype wire
